// ===== rtl/hyp_pkg.sv =====
// Shared constants and pipeline payload types for the fixed-point hypot block.
`default_nettype none
package hyp_pkg;

  localparam int NEWTON_STEPS_DEF = 3;
  localparam int VALUE_WIDTH_DEF  = 32;

  localparam int FIELD_W   = 32;
  localparam int OUT_W     = 31;
  localparam int FRAC_BITS = 16;
  localparam int MAG_W     = 32;
  localparam int ROOT_W    = MAG_W + 1;
  localparam int NUM_W     = MAG_W + FRAC_BITS + 1;
  localparam int QUO_W     = 32;
  localparam int PROD_W    = MAG_W + QUO_W - FRAC_BITS;
  localparam int SUM_W     = PROD_W + 2;

  localparam logic [MAG_W+QUO_W-1:0] ROUND_HALF = (MAG_W+QUO_W)'(64'h8000);
  localparam logic [QUO_W-1:0]       QUO_MAX    = '1;

  typedef struct packed {
    logic [MAG_W-1:0]  a;
    logic [MAG_W-1:0]  b;
    logic [ROOT_W-1:0] root;
    logic              byp;
  } step_t;

  typedef struct packed {
    step_t             base;
    logic [NUM_W-1:0]  na;
    logic [NUM_W-1:0]  nb;
    logic [ROOT_W-1:0] ra;
    logic [ROOT_W-1:0] rb;
    logic [NUM_W-1:0]  qa;
    logic [NUM_W-1:0]  qb;
  } div_t;

  typedef struct packed {
    step_t             base;
    logic [PROD_W-1:0] pa;
    logic [PROD_W-1:0] pb;
  } mul_t;

endpackage
`default_nettype wire

// ===== rtl/hyp_in_if.sv =====
// Operand channel: two signed 16.16 components with valid/ready.
`default_nettype none
interface hyp_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [hyp_pkg::FIELD_W-1:0] a_value;
  logic signed [hyp_pkg::FIELD_W-1:0] b_value;

  modport source (output valid, output a_value, output b_value, input ready);
  modport sink (input valid, input a_value, input b_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/hyp_out_if.sv =====
// Result channel: unsigned 15.16 distance with valid/ready.
`default_nettype none
interface hyp_out_if;
  logic                       valid;
  logic                       ready;
  logic [hyp_pkg::OUT_W-1:0]  distance;

  modport source (output valid, output distance, input ready);
  modport sink (input valid, input distance, output ready);
endinterface
`default_nettype wire

// ===== rtl/hyp_div_stage.sv =====
// One restoring-division bit for both quotients of a Newton step, registered.
`default_nettype none
module hyp_div_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire logic          src_valid,
  input  wire hyp_pkg::div_t src_data,
  output logic               dst_valid,
  output hyp_pkg::div_t      dst_data
);

  logic [hyp_pkg::ROOT_W:0]   dvs;
  logic [hyp_pkg::ROOT_W:0]   ta;
  logic [hyp_pkg::ROOT_W:0]   tb;
  logic [hyp_pkg::ROOT_W:0]   da;
  logic [hyp_pkg::ROOT_W:0]   db;
  logic                       ge_a;
  logic                       ge_b;
  hyp_pkg::div_t              data_next;

  always_comb begin
    dvs  = {1'b0, src_data.base.root};
    ta   = {src_data.ra, src_data.na[hyp_pkg::NUM_W-1]};
    tb   = {src_data.rb, src_data.nb[hyp_pkg::NUM_W-1]};
    ge_a = (ta >= dvs);
    ge_b = (tb >= dvs);
    da   = ta - dvs;
    db   = tb - dvs;
    data_next      = src_data;
    data_next.ra   = ge_a ? da[hyp_pkg::ROOT_W-1:0] : ta[hyp_pkg::ROOT_W-1:0];
    data_next.rb   = ge_b ? db[hyp_pkg::ROOT_W-1:0] : tb[hyp_pkg::ROOT_W-1:0];
    data_next.na   = {src_data.na[hyp_pkg::NUM_W-2:0], 1'b0};
    data_next.nb   = {src_data.nb[hyp_pkg::NUM_W-2:0], 1'b0};
    data_next.qa   = {src_data.qa[hyp_pkg::NUM_W-2:0], ge_a};
    data_next.qb   = {src_data.qb[hyp_pkg::NUM_W-2:0], ge_b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (adv) begin
      dst_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dst_data <= data_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/hyp_newton_step.sv =====
// One Newton refinement: two pipelined divisions, a multiply stage and a sum stage.
`default_nettype none
module hyp_newton_step (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           adv,
  input  wire logic           src_valid,
  input  wire hyp_pkg::step_t src_data,
  output logic                dst_valid,
  output hyp_pkg::step_t      dst_data
);

  hyp_pkg::div_t                   chain_data  [hyp_pkg::NUM_W+1];
  logic                            chain_valid [hyp_pkg::NUM_W+1];
  hyp_pkg::div_t                   last;
  logic [hyp_pkg::QUO_W-1:0]       qca;
  logic [hyp_pkg::QUO_W-1:0]       qcb;
  logic [hyp_pkg::MAG_W+hyp_pkg::QUO_W-1:0] prod_a;
  logic [hyp_pkg::MAG_W+hyp_pkg::QUO_W-1:0] prod_b;
  hyp_pkg::mul_t                   mul_next;
  hyp_pkg::mul_t                   mul;
  logic                            mul_valid;
  logic [hyp_pkg::SUM_W-1:0]       sum;
  hyp_pkg::step_t                  data_next;

  always_comb begin
    chain_valid[0]     = src_valid;
    chain_data[0].base = src_data;
    chain_data[0].na   = (hyp_pkg::NUM_W'(src_data.a) << hyp_pkg::FRAC_BITS)
                         + hyp_pkg::NUM_W'(src_data.root >> 1);
    chain_data[0].nb   = (hyp_pkg::NUM_W'(src_data.b) << hyp_pkg::FRAC_BITS)
                         + hyp_pkg::NUM_W'(src_data.root >> 1);
    chain_data[0].ra   = '0;
    chain_data[0].rb   = '0;
    chain_data[0].qa   = '0;
    chain_data[0].qb   = '0;
  end

  for (genvar i = 0; i < hyp_pkg::NUM_W; i++) begin : g_div
    hyp_div_stage u_div (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .src_valid (chain_valid[i]),
      .src_data  (chain_data[i]),
      .dst_valid (chain_valid[i+1]),
      .dst_data  (chain_data[i+1])
    );
  end

  always_comb begin
    last   = chain_data[hyp_pkg::NUM_W];
    qca    = (last.qa > hyp_pkg::NUM_W'(hyp_pkg::QUO_MAX)) ? hyp_pkg::QUO_MAX
             : last.qa[hyp_pkg::QUO_W-1:0];
    qcb    = (last.qb > hyp_pkg::NUM_W'(hyp_pkg::QUO_MAX)) ? hyp_pkg::QUO_MAX
             : last.qb[hyp_pkg::QUO_W-1:0];
    prod_a = ((hyp_pkg::MAG_W+hyp_pkg::QUO_W)'(last.base.a)
              * (hyp_pkg::MAG_W+hyp_pkg::QUO_W)'(qca)) + hyp_pkg::ROUND_HALF;
    prod_b = ((hyp_pkg::MAG_W+hyp_pkg::QUO_W)'(last.base.b)
              * (hyp_pkg::MAG_W+hyp_pkg::QUO_W)'(qcb)) + hyp_pkg::ROUND_HALF;
    mul_next.base = last.base;
    mul_next.pa   = prod_a[hyp_pkg::MAG_W+hyp_pkg::QUO_W-1:hyp_pkg::FRAC_BITS];
    mul_next.pb   = prod_b[hyp_pkg::MAG_W+hyp_pkg::QUO_W-1:hyp_pkg::FRAC_BITS];
  end

  always_comb begin
    sum = hyp_pkg::SUM_W'(mul.base.root) + hyp_pkg::SUM_W'(mul.pa)
          + hyp_pkg::SUM_W'(mul.pb) + hyp_pkg::SUM_W'(1);
    data_next      = mul.base;
    data_next.root = sum[hyp_pkg::ROOT_W:1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      dst_valid <= 1'b0;
    end else if (adv) begin
      mul_valid <= chain_valid[hyp_pkg::NUM_W];
      dst_valid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mul      <= mul_next;
      dst_data <= data_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/fixed_point_hypot_newton.sv =====
// Top level of the pipelined fixed-point Euclidean length unit.
// Takes two signed 16.16 components and returns sqrt(a*a + b*b) in unsigned
// 15.16, saturated. The datapath is a single pipeline: one magnitude/seed
// stage, then NEWTON_STEPS refinement steps of 51 stages each (49 restoring
// division bits, one multiply, one sum), then the output register.
// One operand pair is accepted every cycle; when the result is not taken the
// whole pipeline holds, bubbles included, and nothing is accepted during reset.
`default_nettype none
module fixed_point_hypot_newton #(
  parameter int NEWTON_STEPS = hyp_pkg::NEWTON_STEPS_DEF,
  parameter int VALUE_WIDTH  = hyp_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  hyp_in_if.sink    operands,
  hyp_out_if.source result
);

  localparam int EW = (VALUE_WIDTH < hyp_pkg::FIELD_W) ? VALUE_WIDTH
                                                       : hyp_pkg::FIELD_W;
  localparam logic [hyp_pkg::MAG_W-1:0] MASK =
    hyp_pkg::MAG_W'((65'(1) << EW) - 65'(1));
  localparam logic [hyp_pkg::ROOT_W-1:0] LIM_W =
    hyp_pkg::ROOT_W'((65'(1) << (EW - 1)) - 65'(1));
  localparam logic [hyp_pkg::ROOT_W-1:0] LIM_O =
    hyp_pkg::ROOT_W'((65'(1) << hyp_pkg::OUT_W) - 65'(1));
  localparam logic [hyp_pkg::ROOT_W-1:0] LIM = (LIM_W < LIM_O) ? LIM_W : LIM_O;

  logic                          adv;
  logic [hyp_pkg::MAG_W-1:0]     va;
  logic [hyp_pkg::MAG_W-1:0]     vb;
  logic [hyp_pkg::MAG_W-1:0]     ma;
  logic [hyp_pkg::MAG_W-1:0]     mb;
  hyp_pkg::step_t                seed_next;
  hyp_pkg::step_t                step_data  [NEWTON_STEPS+1];
  logic                          step_valid [NEWTON_STEPS+1];
  hyp_pkg::step_t                fin;
  logic [hyp_pkg::ROOT_W-1:0]    pick;
  logic [hyp_pkg::ROOT_W-1:0]    clamped;
  logic                          out_valid;
  logic [hyp_pkg::OUT_W-1:0]     distance;

  assign adv            = !out_valid || result.ready;
  assign operands.ready = adv && !rst;
  assign result.valid   = out_valid;
  assign result.distance = distance;

  always_comb begin
    va = hyp_pkg::MAG_W'(operands.a_value) & MASK;
    vb = hyp_pkg::MAG_W'(operands.b_value) & MASK;
    ma = va[EW-1] ? ((~va) + hyp_pkg::MAG_W'(1)) & MASK : va;
    mb = vb[EW-1] ? ((~vb) + hyp_pkg::MAG_W'(1)) & MASK : vb;
    seed_next.a    = ma;
    seed_next.b    = mb;
    seed_next.byp  = (ma == '0) || (mb == '0);
    seed_next.root = (ma > mb) ? hyp_pkg::ROOT_W'(ma) + hyp_pkg::ROOT_W'(mb >> 1)
                               : hyp_pkg::ROOT_W'(mb) + hyp_pkg::ROOT_W'(ma >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_valid[0] <= 1'b0;
    end else if (adv) begin
      step_valid[0] <= operands.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      step_data[0] <= seed_next;
    end
  end

  for (genvar s = 0; s < NEWTON_STEPS; s++) begin : g_step
    hyp_newton_step u_step (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .src_valid (step_valid[s]),
      .src_data  (step_data[s]),
      .dst_valid (step_valid[s+1]),
      .dst_data  (step_data[s+1])
    );
  end

  always_comb begin
    fin     = step_data[NEWTON_STEPS];
    pick    = fin.byp ? hyp_pkg::ROOT_W'(fin.a | fin.b) : fin.root;
    clamped = (pick > LIM) ? LIM : pick;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= step_valid[NEWTON_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      distance <= clamped[hyp_pkg::OUT_W-1:0];
    end
  end

endmodule
`default_nettype wire
